// File: design/sids_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sids_pkg;

    // Configuration bus geometry: seven 32-bit registers at word addresses.
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int INDEX_BITS = 3;

    // Register indexes, taken from paddr[4:2].
    localparam logic [INDEX_BITS-1:0] REG_RUN_TEMP         = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_IDLE_TEMP        = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_RUN_TIME_TICKS   = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_APPROACH_BAND    = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_DUTY_MIN         = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_DUTY_MAX         = 3'd5;
    localparam logic [INDEX_BITS-1:0] REG_CUP_NOT_REQUIRED = 3'd6;

    localparam logic [7:0] BAND_RESET     = 8'd5;
    localparam logic [9:0] DUTY_MAX_RESET = 10'd1000;

    typedef enum logic [1:0] {
        PHASE_APPROACH = 2'd0,
        PHASE_SOAK     = 2'd1,
        PHASE_IDLE     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        LED_NONE = 2'd0,
        LED_HEAT = 2'd1,
        LED_COOL = 2'd2
    } led_t;

    typedef struct packed {
        logic               run_mode;
        logic               cup_present;
        logic signed [15:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  heater_duty;
        logic [9:0]  peltier_duty;
        logic [9:0]  fan_duty;
        logic [1:0]  led_mode;
        logic [1:0]  soak_phase;
        logic [23:0] time_left;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] run_temp;
        logic signed [15:0] idle_temp;
        logic [23:0]        run_time_ticks;
        logic [7:0]         approach_band;
        logic [9:0]         duty_min;
        logic [9:0]         duty_max;
        logic               cup_not_required;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/sids_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sids_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sids_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [sids_pkg::DATA_BITS-1:0] pwdata,
    output logic      [sids_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready,
    output sids_pkg::cfg_t                      cfg
);

    sids_pkg::cfg_t                    cfg_reg;
    sids_pkg::cfg_t                    cfg_next;
    logic [sids_pkg::INDEX_BITS-1:0]   index;
    logic                              wr_en;

    assign index  = paddr[sids_pkg::ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                sids_pkg::REG_RUN_TEMP:         cfg_next.run_temp         = pwdata[15:0];
                sids_pkg::REG_IDLE_TEMP:        cfg_next.idle_temp        = pwdata[15:0];
                sids_pkg::REG_RUN_TIME_TICKS:   cfg_next.run_time_ticks   = pwdata[23:0];
                sids_pkg::REG_APPROACH_BAND:    cfg_next.approach_band    = pwdata[7:0];
                sids_pkg::REG_DUTY_MIN:         cfg_next.duty_min         = pwdata[9:0];
                sids_pkg::REG_DUTY_MAX:         cfg_next.duty_max         = pwdata[9:0];
                sids_pkg::REG_CUP_NOT_REQUIRED: cfg_next.cup_not_required = pwdata[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_temp         <= '0;
            cfg_reg.idle_temp        <= '0;
            cfg_reg.run_time_ticks   <= '0;
            cfg_reg.approach_band    <= sids_pkg::BAND_RESET;
            cfg_reg.duty_min         <= '0;
            cfg_reg.duty_max         <= sids_pkg::DUTY_MAX_RESET;
            cfg_reg.cup_not_required <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Reads return the stored bits, zero-filled above the register width.
    always_comb
    begin
        case (index)
            sids_pkg::REG_RUN_TEMP:         prdata = {16'd0, cfg_reg.run_temp};
            sids_pkg::REG_IDLE_TEMP:        prdata = {16'd0, cfg_reg.idle_temp};
            sids_pkg::REG_RUN_TIME_TICKS:   prdata = {8'd0, cfg_reg.run_time_ticks};
            sids_pkg::REG_APPROACH_BAND:    prdata = {24'd0, cfg_reg.approach_band};
            sids_pkg::REG_DUTY_MIN:         prdata = {22'd0, cfg_reg.duty_min};
            sids_pkg::REG_DUTY_MAX:         prdata = {22'd0, cfg_reg.duty_max};
            sids_pkg::REG_CUP_NOT_REQUIRED: prdata = {31'd0, cfg_reg.cup_not_required};
            default:                        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/sids_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sids_core #(
    parameter int TIME_BITS = 24,
    parameter int DUTY_BITS = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire sids_pkg::in_item_t  item,
    input  wire sids_pkg::cfg_t      cfg,
    output sids_pkg::out_item_t      result
);

    // Arithmetic width for the duty steps: room for the level, the 10-bit
    // clamp bounds, a sign and a carry.
    localparam int CW = ((DUTY_BITS > 10) ? DUTY_BITS : 10) + 2;

    logic                    load_pending_reg;
    logic                    load_pending_next;
    sids_pkg::phase_t        phase_reg;
    sids_pkg::phase_t        phase_next;
    logic [TIME_BITS-1:0]    rem_reg;
    logic [TIME_BITS-1:0]    rem_next;
    logic [DUTY_BITS-1:0]    heat_reg;
    logic [DUTY_BITS-1:0]    heat_next;
    logic [DUTY_BITS-1:0]    cool_reg;
    logic [DUTY_BITS-1:0]    cool_next;
    logic [DUTY_BITS-1:0]    fan_reg;
    logic [DUTY_BITS-1:0]    fan_next;
    sids_pkg::out_item_t     out_reg;
    sids_pkg::out_item_t     out_next;

    logic                    active;
    logic [TIME_BITS+23:0]   load_wide;
    logic [TIME_BITS-1:0]    rem_start;
    sids_pkg::phase_t        phase_start;
    sids_pkg::phase_t        phase_band;
    logic [TIME_BITS-1:0]    rem_count;
    sids_pkg::phase_t        phase_count;
    logic signed [17:0]      temp_x;
    logic signed [17:0]      rt_x;
    logic signed [17:0]      band_x;
    logic signed [17:0]      band_lo;
    logic signed [17:0]      band_hi;
    logic                    in_band;
    logic signed [15:0]      target;
    logic                    heating;
    logic                    err_zero;
    logic signed [CW-1:0]    heat_delta;
    logic signed [CW-1:0]    cool_delta;
    logic signed [CW-1:0]    fan_delta;
    logic [DUTY_BITS+9:0]    heat_out_wide;
    logic [DUTY_BITS+9:0]    cool_out_wide;
    logic [DUTY_BITS+9:0]    fan_out_wide;
    logic [TIME_BITS+23:0]   time_out_wide;

    // Step a level by delta, then apply the upper bound and the lower bound
    // last, so crossed bounds leave the level at duty_min.
    function automatic logic [DUTY_BITS-1:0] step_clamp(
        input logic [DUTY_BITS-1:0] level,
        input logic signed [CW-1:0] delta,
        input logic [9:0]           hi,
        input logic [9:0]           lo
    );
        logic signed [CW-1:0] v;
        logic signed [CW-1:0] hi_s;
        logic signed [CW-1:0] lo_s;
        hi_s = signed'({{(CW-10){1'b0}}, hi});
        lo_s = signed'({{(CW-10){1'b0}}, lo});
        v    = signed'({{(CW-DUTY_BITS){1'b0}}, level}) + delta;
        if (v >= hi_s)
            v = hi_s;
        if (v <= lo_s)
            v = lo_s;
        return v[DUTY_BITS-1:0];
    endfunction

    assign active = item.run_mode && (item.cup_present || cfg.cup_not_required);

    // Soak length resized to the counter width.
    assign load_wide   = {{TIME_BITS{1'b0}}, cfg.run_time_ticks};
    assign rem_start   = load_pending_reg ? load_wide[TIME_BITS-1:0] : rem_reg;
    assign phase_start = load_pending_reg ? sids_pkg::PHASE_APPROACH : phase_reg;

    // Strict band test around run_temp, in 18 bits so nothing overflows.
    assign temp_x  = {{2{item.temperature[15]}}, item.temperature};
    assign rt_x    = {{2{cfg.run_temp[15]}}, cfg.run_temp};
    assign band_x  = {10'd0, cfg.approach_band};
    assign band_lo = rt_x - band_x;
    assign band_hi = rt_x + band_x;
    assign in_band = (temp_x > band_lo) && (temp_x < band_hi);

    assign phase_band = ((rem_start != '0) && in_band) ? sids_pkg::PHASE_SOAK : phase_start;

    always_comb
    begin
        rem_count   = rem_start;
        phase_count = phase_band;
        if (phase_band == sids_pkg::PHASE_SOAK)
        begin
            if (rem_start != '0)
                rem_count = rem_start - 1'b1;
            if (rem_count == '0)
                phase_count = sids_pkg::PHASE_IDLE;
        end
    end

    assign target   = (phase_count == sids_pkg::PHASE_IDLE) ? cfg.idle_temp : cfg.run_temp;
    assign heating  = target > item.temperature;
    assign err_zero = target == item.temperature;

    always_comb
    begin
        if (heating)
        begin
            heat_delta = signed'(CW'(1));
            cool_delta = signed'(CW'(-1));
            fan_delta  = signed'(CW'(-1));
        end
        else
        begin
            heat_delta = signed'(CW'(-1));
            cool_delta = signed'(CW'(1));
            fan_delta  = err_zero ? signed'(CW'(0)) : signed'(CW'(1));
        end
    end

    always_comb
    begin
        load_pending_next = load_pending_reg;
        phase_next        = phase_reg;
        rem_next          = rem_reg;
        heat_next         = heat_reg;
        cool_next         = cool_reg;
        fan_next          = fan_reg;
        if (step)
        begin
            if (active)
            begin
                load_pending_next = 1'b0;
                phase_next        = phase_count;
                rem_next          = rem_count;
                heat_next = step_clamp(heat_reg, heat_delta, cfg.duty_max, cfg.duty_min);
                cool_next = step_clamp(cool_reg, cool_delta, cfg.duty_max, cfg.duty_min);
                fan_next  = step_clamp(fan_reg, fan_delta, cfg.duty_max, cfg.duty_min);
            end
            else
            begin
                // Idle tick: duties off, phase kept, soak time reloads later.
                load_pending_next = 1'b1;
                rem_next          = '0;
                heat_next         = '0;
                cool_next         = '0;
                fan_next          = '0;
            end
        end
    end

    assign heat_out_wide = {10'd0, heat_next};
    assign cool_out_wide = {10'd0, cool_next};
    assign fan_out_wide  = {10'd0, fan_next};
    assign time_out_wide = {24'd0, rem_next};

    always_comb
    begin
        out_next = out_reg;
        if (step)
        begin
            out_next.heater_duty  = heat_out_wide[9:0];
            out_next.peltier_duty = cool_out_wide[9:0];
            out_next.fan_duty     = fan_out_wide[9:0];
            out_next.soak_phase   = phase_next;
            out_next.time_left    = time_out_wide[23:0];
            if (!active)
                out_next.led_mode = sids_pkg::LED_NONE;
            else if (heating)
                out_next.led_mode = sids_pkg::LED_HEAT;
            else
                out_next.led_mode = sids_pkg::LED_COOL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pending_reg <= 1'b1;
            phase_reg        <= sids_pkg::PHASE_APPROACH;
            rem_reg          <= '0;
            heat_reg         <= '0;
            cool_reg         <= '0;
            fan_reg          <= '0;
        end
        else
        begin
            load_pending_reg <= load_pending_next;
            phase_reg        <= phase_next;
            rem_reg          <= rem_next;
            heat_reg         <= heat_next;
            cool_reg         <= cool_next;
            fan_reg          <= fan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result = out_reg;

    // An idle tick re-arms the soak load and clears the countdown.
    a_idle_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !active) |=> (load_pending_reg && (rem_reg == '0)))
        else $error("idle tick did not re-arm the soak load");

    // An active tick always consumes the pending load.
    a_active_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step && active) |=> !load_pending_reg)
        else $error("active tick left the soak load pending");

    // After an active tick, soaking always has ticks left; zero means idle target.
    a_soak_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        (step && active) |=> ((phase_reg != sids_pkg::PHASE_SOAK) || (rem_reg != '0)))
        else $error("soak phase with no ticks left");

    // An idle tick reports zero duties and no heating or cooling mark.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !active) |=> ((out_reg.heater_duty == '0) && (out_reg.peltier_duty == '0)
                               && (out_reg.fan_duty == '0)
                               && (out_reg.led_mode == sids_pkg::LED_NONE)))
        else $error("idle tick drove a duty");

endmodule

`default_nettype wire

// File: design/soak_then_idle_duty_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Beat
// in        input      in_valid / in_ready        sids_pkg::in_item_t, one control tick
// out       output     out_valid / out_ready      sids_pkg::out_item_t, one result per tick
// cfg       input      psel / penable / pwrite    32-bit register write or read, pready high
//
// One tick beat is accepted per cycle while the output keeps up; the soak and
// duty state update, which each tick reads from the one before, sets that
// rate. out_valid rises once the control step has moved a beat into the result register.
// Reset (rst_n low, asynchronous) empties both stages, re-arms the soak load
// and restores register defaults. With out_ready low a full result holds, one
// more beat parks in the input register, and in_ready then drops.
module soak_then_idle_duty_stepper #(
    parameter int TIME_BITS = 24,
    parameter int DUTY_BITS = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire sids_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output sids_pkg::out_item_t                 out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sids_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [sids_pkg::DATA_BITS-1:0] pwdata,
    output logic      [sids_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready
);

    sids_pkg::cfg_t     cfg;
    sids_pkg::in_item_t stage_data_reg;
    sids_pkg::in_item_t stage_data_next;
    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;
    logic               step;
    logic               in_fire;

    sids_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The result register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;
    // The parked tick advances into the control step whenever there is room.
    assign step     = stage_valid_reg && out_free;
    assign in_ready = !stage_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_data_next  = stage_data_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
            stage_data_next  = in_data;
        end
        else if (step)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_data_reg <= stage_data_next;
    end

    sids_core #(
        .TIME_BITS (TIME_BITS),
        .DUTY_BITS (DUTY_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_data_reg),
        .cfg    (cfg),
        .result (out_data)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
